>>> hw/rtl/assert_macros.svh
// Assertion macros used by stq_ctrl.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/stq_pkg.sv
// Package for the sorted timer expiry queue: constants, request codes, types.
// No dependencies.
package stq_pkg;
   localparam int unsigned NumTimersDefault = 16;
   localparam logic [63:0] IdleWaitReset = 64'd60000;
   localparam int unsigned KindWidth = 3;
   localparam int unsigned IdWidth = 4;
   localparam int unsigned TimeWidth = 64;

   localparam logic [KindWidth-1:0] KindSet   = 3'd0;
   localparam logic [KindWidth-1:0] KindReset = 3'd1;
   localparam logic [KindWidth-1:0] KindStop  = 3'd2;
   localparam logic [KindWidth-1:0] KindRun   = 3'd3;
   localparam logic [KindWidth-1:0] KindQuery = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXP_RD,
      ST_EXP_CALC,
      ST_UNLINK,
      ST_FIND,
      ST_FIND_CMP,
      ST_INSERT,
      ST_HEAD_RD,
      ST_HEAD_CMP,
      ST_RESULT
   } stq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;       // latch request item
      logic exp_rd;        // read expiry of request timer, note old head
      logic exp_calc;      // compute and store new expiry
      logic scan_start;    // clear scan index
      logic unlink_step;   // one step of removal scan
      logic find_rd;       // insert search: read expiry at scan index
      logic find_cmp;      // insert search: compare returned expiry
      logic insert_step;   // one step of shifting insert
      logic head_rd;       // read expiry of queue head
      logic head_cmp;      // evaluate run or query answer
      logic result_load;   // load output register
   } stq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic unlink_done;
      logic find_end;
      logic find_hit;
      logic insert_done;
      logic id_ok;
      logic pop;
   } stq_stat_type;
endpackage

>>> hw/rtl/sorted_timer_expiry_queue_unit.sv
// Top level of the sorted timer expiry queue.
// Depends on stq_pkg, stq_ctrl, stq_dp.
//
//  channel | handshake             | payload
//  req     | req_valid/req_ready   | kind, timer_id, now, delta
//  rsp     | rsp_valid/rsp_ready   | head_changed .. time_to_next
//  csr     | csr_valid/csr_ready   | idle_wait write data
//
// One item at a time: a new request is taken only in the idle state, after the
// result of the last is loaded. An unused kind or an out-of-range id goes straight
// to the result; query reads the head; run reads the head and may unlink it; set or
// reset runs a linear unlink scan, an insert search with a read and a compare per
// entry, and a shifting insert. Synchronous reset empties the queue; expiry entries
// never written read as zero. A waiting result holds the unit in its last state.
module sorted_timer_expiry_queue_unit
   import stq_pkg::*;
#(
   parameter int unsigned NumTimers = NumTimersDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KindWidth-1:0] req_kind,
   input  logic [IdWidth-1:0]   req_timer_id,
   input  logic [TimeWidth-1:0] req_now,
   input  logic [TimeWidth-1:0] req_delta,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_head_changed,
   output logic                 rsp_expired_valid,
   output logic [IdWidth-1:0]   rsp_expired_id,
   output logic                 rsp_run_again,
   output logic [TimeWidth-1:0] rsp_time_to_next,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TimeWidth-1:0] csr_idle_wait
);
   stq_cmd_type  cmd;
   stq_stat_type stat;
   logic [TimeWidth-1:0] idle_wait_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_wait_ff <= IdleWaitReset;
      end else if (csr_valid && csr_ready) begin
         idle_wait_ff <= csr_idle_wait;
      end
   end

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .kind      (req_kind),
      .cmd       (cmd),
      .stat      (stat)
   );

   stq_dp #(.NumTimers(NumTimers)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_timer_id      (req_timer_id),
      .req_now           (req_now),
      .req_delta         (req_delta),
      .idle_wait         (idle_wait_ff),
      .rsp_head_changed  (rsp_head_changed),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_run_again     (rsp_run_again),
      .rsp_time_to_next  (rsp_time_to_next)
   );
endmodule

>>> hw/rtl/stq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module stq_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/stq_ctrl.sv
// Controller state machine of the sorted timer queue.
// Depends on stq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stq_ctrl
   import stq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [KindWidth-1:0] kind,
   output stq_cmd_type          cmd,
   input  stq_stat_type         stat
);
   stq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KindWidth-1:0] kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KindSet;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               kind_in     = kind;
               state_in    = ST_EXP_RD;
            end
         end
         ST_EXP_RD: begin
            cmd.exp_rd = 1'b1;
            unique case (kind_ff) inside
               KindSet, KindReset, KindStop: begin
                  state_in = stat.id_ok ? ST_EXP_CALC : ST_RESULT;
               end
               KindRun, KindQuery: begin
                  state_in = ST_HEAD_RD;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_EXP_CALC: begin
            cmd.exp_calc   = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_UNLINK;
         end
         ST_UNLINK: begin
            cmd.unlink_step = 1'b1;
            if (stat.unlink_done) begin
               cmd.scan_start = 1'b1;
               unique case (kind_ff) inside
                  KindStop: state_in = ST_RESULT;
                  KindRun:  state_in = ST_HEAD_RD;
                  default:  state_in = ST_FIND;
               endcase
            end
         end
         ST_FIND: begin
            cmd.find_rd = 1'b1;
            state_in = stat.find_end ? ST_INSERT : ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            cmd.find_cmp = 1'b1;
            state_in = stat.find_hit ? ST_INSERT : ST_FIND;
         end
         ST_INSERT: begin
            cmd.insert_step = 1'b1;
            if (stat.insert_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_HEAD_RD: begin
            cmd.head_rd = 1'b1;
            state_in = ST_HEAD_CMP;
         end
         ST_HEAD_CMP: begin
            cmd.head_cmp = 1'b1;
            if (stat.pop) begin
               cmd.scan_start = 1'b1;
               state_in = ST_UNLINK;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_load_valid, clock, reset, cmd.result_load, rsp_valid_ff)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff)
   `ASSERT_IMP(a_one_step, clock, reset, 1'b1,
      $countones({cmd.unlink_step, cmd.find_rd, cmd.find_cmp, cmd.insert_step}) <= 1)
endmodule

>>> hw/rtl/stq_dp.sv
// Datapath of the sorted timer queue: expiry RAM, ordered id list, scans.
// Depends on stq_pkg and stq_ram.
module stq_dp
   import stq_pkg::*;
#(
   parameter int unsigned NumTimers = NumTimersDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_cmd_type          cmd,
   output stq_stat_type         stat,
   input  logic [KindWidth-1:0] req_kind,
   input  logic [IdWidth-1:0]   req_timer_id,
   input  logic [TimeWidth-1:0] req_now,
   input  logic [TimeWidth-1:0] req_delta,
   input  logic [TimeWidth-1:0] idle_wait,
   output logic                 rsp_head_changed,
   output logic                 rsp_expired_valid,
   output logic [IdWidth-1:0]   rsp_expired_id,
   output logic                 rsp_run_again,
   output logic [TimeWidth-1:0] rsp_time_to_next
);
   localparam int unsigned Aw = $clog2(NumTimers);
   localparam int unsigned Cw = $clog2(NumTimers + 1);

   logic [KindWidth-1:0] kind_ff;
   logic [IdWidth-1:0]   id_ff, eid_ff;
   logic [TimeWidth-1:0] now_ff, delta_ff, exp_ff, ttn_ff;
   logic                 hc_ff, ev_ff, again_ff, popped_ff;
   logic                 had_head_ff, found_ff;
   logic [Aw-1:0]        head_before_ff, unlink_id_ff, ram_ra_ff;
   logic [Cw-1:0]        count_ff, idx_ff, pos_ff;
   logic [Aw-1:0]        order_ff [NumTimers];
   logic [NumTimers-1:0] pending_ff;
   logic [NumTimers-1:0] written_ff;

   logic                 id_ok, empty, head_due, pop;
   logic [Aw-1:0]        id_a, new_head;
   logic                 ram_we;
   logic [Aw-1:0]        ram_ra;
   logic [TimeWidth-1:0] ram_wd, ram_rd, exp_val;
   logic                 unlink_hit, unlink_done, find_end, find_hit, insert_done;

   assign id_ok = (32'(id_ff) < NumTimers);
   assign id_a  = Aw'(id_ff);
   // entries never written read as zero
   assign exp_val = written_ff[ram_ra_ff] ? ram_rd : '0;

   stq_ram #(.Width(TimeWidth), .Depth(NumTimers)) u_exp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (id_a),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      ram_ra = id_a;
      if (cmd.head_rd) begin
         ram_ra = order_ff[0];
      end else if (cmd.find_rd) begin
         ram_ra = order_ff[Aw'(idx_ff)];
      end
   end

   assign ram_we = cmd.exp_calc;
   always_comb begin
      case (kind_ff)
         KindSet:   ram_wd = now_ff + delta_ff;
         KindReset: ram_wd = exp_val + delta_ff;
         default:   ram_wd = now_ff;
      endcase
   end

   assign empty       = (count_ff == '0);
   assign head_due    = !empty && (exp_val <= now_ff);
   assign pop         = (kind_ff == KindRun) && !popped_ff && head_due;
   assign unlink_hit  = found_ff || (order_ff[Aw'(idx_ff)] == unlink_id_ff);
   assign unlink_done = !pending_ff[unlink_id_ff] || (idx_ff >= count_ff);
   assign find_end    = (idx_ff >= count_ff);
   assign find_hit    = (exp_ff < exp_val);
   assign insert_done = (idx_ff <= pos_ff);
   assign new_head    = (pos_ff == '0) ? id_a : order_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= '0;
         written_ff <= '0;
      end else begin
         if (ram_we) begin
            written_ff[id_a] <= 1'b1;
         end
         if (cmd.unlink_step && pending_ff[unlink_id_ff]) begin
            if (unlink_done) begin
               count_ff <= count_ff - Cw'(1);
               pending_ff[unlink_id_ff] <= 1'b0;
            end else if (unlink_hit && (idx_ff + Cw'(1) < count_ff)) begin
               order_ff[Aw'(idx_ff)] <= order_ff[Aw'(idx_ff + Cw'(1))];
            end
         end
         if (cmd.insert_step) begin
            if (!insert_done) begin
               order_ff[Aw'(idx_ff)] <= order_ff[Aw'(idx_ff - Cw'(1))];
            end else begin
               order_ff[Aw'(pos_ff)] <= id_a;
               count_ff <= count_ff + Cw'(1);
               pending_ff[id_a] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ram_ra_ff <= ram_ra;
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         id_ff     <= req_timer_id;
         now_ff    <= req_now;
         delta_ff  <= req_delta;
         hc_ff     <= 1'b0;
         ev_ff     <= 1'b0;
         eid_ff    <= '0;
         again_ff  <= 1'b0;
         ttn_ff    <= '0;
         popped_ff <= 1'b0;
      end
      if (cmd.exp_rd) begin
         had_head_ff    <= !empty;
         head_before_ff <= order_ff[0];
         unlink_id_ff   <= id_a;
      end
      if (cmd.exp_calc) begin
         exp_ff <= ram_wd;
      end
      if (cmd.scan_start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.unlink_step) begin
         if (!unlink_done) begin
            if (unlink_hit) begin
               found_ff <= 1'b1;
            end
            idx_ff <= idx_ff + Cw'(1);
         end
      end else if (cmd.find_rd) begin
         if (find_end) begin
            pos_ff <= count_ff;
         end
      end else if (cmd.find_cmp) begin
         if (find_hit) begin
            pos_ff <= idx_ff;
            idx_ff <= count_ff;
         end else begin
            idx_ff <= idx_ff + Cw'(1);
         end
      end else if (cmd.insert_step) begin
         if (!insert_done) begin
            idx_ff <= idx_ff - Cw'(1);
         end
      end
      if (cmd.head_cmp) begin
         if (popped_ff) begin
            again_ff <= head_due;
         end else if (kind_ff == KindQuery) begin
            if (empty) begin
               ttn_ff <= idle_wait;
            end else begin
               ttn_ff <= (now_ff < exp_val) ? exp_val - now_ff : '0;
            end
         end else if (pop) begin
            hc_ff        <= 1'b1;
            ev_ff        <= 1'b1;
            eid_ff       <= IdWidth'(order_ff[0]);
            unlink_id_ff <= order_ff[0];
            popped_ff    <= 1'b1;
         end
      end
      if (cmd.insert_step && insert_done) begin
         hc_ff <= !had_head_ff || (new_head != head_before_ff);
      end
   end

   assign stat.unlink_done = unlink_done;
   assign stat.find_end    = find_end;
   assign stat.find_hit    = find_hit;
   assign stat.insert_done = insert_done;
   assign stat.id_ok       = id_ok;
   assign stat.pop         = pop;

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_head_changed  <= hc_ff;
         rsp_expired_valid <= ev_ff;
         rsp_expired_id    <= eid_ff;
         rsp_run_again     <= again_ff;
         rsp_time_to_next  <= ttn_ff;
      end
   end
endmodule

>>> bench/tb_top.sv
// Self-checking bench for sorted_timer_expiry_queue_unit: directed and random requests,
// checked against an in-bench model of the sorted timer queue.
// Depends on stq_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top
   import stq_pkg::*;
();

   localparam int NTimers = NumTimersDefault;
   localparam logic [KindWidth-1:0] KindSpare = 3'd5;
   localparam logic [KindWidth-1:0] KindSpareMid = 3'd6;
   localparam logic [KindWidth-1:0] KindSpareHi = 3'd7;
   localparam int DrainCycles = 3 * NTimers + 16;
   localparam longint CycleLimit = 3000000;

   typedef struct {
      logic [KindWidth-1:0] kind;
      logic [IdWidth-1:0]   id;
      logic [63:0]          now;
      logic [63:0]          delta;
   } timer_req_type;

   typedef struct {
      bit          head_changed;
      bit          expired_valid;
      bit [3:0]    expired_id;
      bit          run_again;
      bit [63:0]   time_to_next;
   } timer_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [KindWidth-1:0] req_kind = '0;
   logic [IdWidth-1:0] req_timer_id = '0;
   logic [63:0] req_now = '0;
   logic [63:0] req_delta = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_head_changed, rsp_expired_valid, rsp_run_again;
   logic [IdWidth-1:0] rsp_expired_id;
   logic [63:0] rsp_time_to_next;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [63:0] csr_idle_wait = '0;

   timer_req_type pending_reqs[$];
   timer_rsp_type expected_rsps[$];
   timer_req_type cur_req;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_pops = 0;
   longint cycles = 0;

   // model state
   logic [63:0] mdl_expiry[NTimers];
   bit          mdl_armed[NTimers];
   int          mdl_order[NTimers];
   int          mdl_count = 0;
   logic [63:0] mdl_idle_wait = IdleWaitReset;

   int tx_gap = 0;
   int rx_stall = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   bit tx_quiet = 1'b0;
   logic [63:0] base_now = 64'd1000;

   sorted_timer_expiry_queue_unit dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void drop_timer(int id);
      int i;
      int j;
      if (!mdl_armed[id]) return;
      for (i = 0; i < mdl_count; i++) begin
         if (mdl_order[i] == id) begin
            for (j = i; j + 1 < mdl_count; j++) mdl_order[j] = mdl_order[j + 1];
            mdl_count--;
            break;
         end
      end
      mdl_armed[id] = 1'b0;
   endfunction

   function automatic bit insert_timer(int id);
      bit had_head;
      int old_head;
      int pos;
      int j;
      had_head = mdl_count > 0;
      old_head = had_head ? mdl_order[0] : 0;
      drop_timer(id);
      pos = mdl_count;
      for (j = 0; j < mdl_count; j++) begin
         if (mdl_expiry[id] < mdl_expiry[mdl_order[j]]) begin
            pos = j;
            break;
         end
      end
      for (j = mdl_count; j > pos; j--) mdl_order[j] = mdl_order[j - 1];
      mdl_order[pos] = id;
      mdl_count++;
      mdl_armed[id] = 1'b1;
      return !had_head || old_head != mdl_order[0];
   endfunction

   function automatic timer_rsp_type predict_timer(timer_req_type r);
      timer_rsp_type o;
      int id;
      int hd;
      logic [63:0] e;
      o = '{default: 0};
      id = r.id;
      case (r.kind)
         KindSet: begin
            mdl_expiry[id] = r.now + r.delta;
            o.head_changed = insert_timer(id);
         end
         KindReset: begin
            mdl_expiry[id] = mdl_expiry[id] + r.delta;
            o.head_changed = insert_timer(id);
         end
         KindStop: begin
            mdl_expiry[id] = r.now;
            drop_timer(id);
         end
         KindRun: begin
            if (mdl_count > 0 && mdl_expiry[mdl_order[0]] <= r.now) begin
               hd = mdl_order[0];
               drop_timer(hd);
               o.head_changed = 1;
               o.expired_valid = 1;
               o.expired_id = hd[3:0];
               o.run_again = mdl_count > 0 && mdl_expiry[mdl_order[0]] <= r.now;
            end
         end
         KindQuery: begin
            if (mdl_count == 0) begin
               o.time_to_next = mdl_idle_wait;
            end else begin
               e = mdl_expiry[mdl_order[0]];
               o.time_to_next = (r.now < e) ? e - r.now : 64'd0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      bit nv;
      int r;
      nv = req_valid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_timer(cur_req));
            if (cur_req.kind == KindRun && expected_rsps[$].expired_valid) n_pops++;
            n_sent++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_kind <= cur_req.kind;
               req_timer_id <= cur_req.id;
               req_now <= cur_req.now;
               req_delta <= cur_req.delta;
               nv = 1'b1;
               r = $urandom_range(0, 99);
               if ($urandom_range(0, 199) == 0) tx_quiet = !tx_quiet;
               if (tx_quiet || r < 55) tx_gap = 0;
               else if (r < 88) tx_gap = $urandom_range(1, 3);
               else if (r < 97) tx_gap = $urandom_range(4, 15);
               else tx_gap = $urandom_range(30, 90);
            end
         end
      end
      req_valid <= nv;
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      timer_rsp_type x;
      int r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item, head_changed=%0b time_to_next=%0h", $time,
                     rsp_head_changed, rsp_time_to_next);
            errors++;
         end else begin
            x = expected_rsps.pop_front();
            n_checked++;
            if (rsp_head_changed !== x.head_changed) begin
               $display("%0t: head_changed exp %0b got %0b", $time, x.head_changed,
                        rsp_head_changed);
               errors++;
            end
            if (rsp_expired_valid !== x.expired_valid) begin
               $display("%0t: expired_valid exp %0b got %0b", $time, x.expired_valid,
                        rsp_expired_valid);
               errors++;
            end
            if (rsp_expired_id !== x.expired_id) begin
               $display("%0t: expired_id exp %0d got %0d", $time, x.expired_id,
                        rsp_expired_id);
               errors++;
            end
            if (rsp_run_again !== x.run_again) begin
               $display("%0t: run_again exp %0b got %0b", $time, x.run_again, rsp_run_again);
               errors++;
            end
            if (rsp_time_to_next !== x.time_to_next) begin
               $display("%0t: time_to_next exp %0h got %0h", $time, x.time_to_next,
                        rsp_time_to_next);
               errors++;
            end
         end
      end
      r = $urandom_range(0, 99);
      if (rx_stall > 0) rx_stall--;
      else if ($urandom_range(0, 149) == 0) rx_stall = $urandom_range(10, 60);
      rsp_ready <= !reset && hold_left == 0 && rx_stall == 0 && (tx_quiet || r < 75);
   end

   task automatic add_req(logic [2:0] k, int id, logic [63:0] now, logic [63:0] delta);
      timer_req_type t;
      t.kind = k;
      t.id = id[3:0];
      t.now = now;
      t.delta = delta;
      pending_reqs.push_back(t);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_idle_wait(logic [63:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_idle_wait <= v;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      mdl_idle_wait = v;
   endtask

   task automatic random_reqs(int n);
      int r;
      logic [63:0] now;
      logic [63:0] delta;
      for (int i = 0; i < n; i++) begin
         base_now = base_now + $urandom_range(0, 40);
         now = base_now;
         if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
         r = $urandom_range(0, 99);
         if (r < 75) delta = $urandom_range(0, 300);
         else if (r < 90) delta = $urandom_range(0, 3);
         else if (r < 97) delta = {$urandom, $urandom};
         else delta = {64{1'b1}} - $urandom_range(0, 2);
         r = $urandom_range(0, 99);
         if (r < 33) add_req(KindSet, $urandom_range(0, 15), now, delta);
         else if (r < 43) add_req(KindReset, $urandom_range(0, 15), now, delta);
         else if (r < 53) add_req(KindStop, $urandom_range(0, 15), now, delta);
         else if (r < 83) add_req(KindRun, $urandom_range(0, 15), now, delta);
         else if (r < 97) add_req(KindQuery, $urandom_range(0, 15), now, delta);
         else add_req(3'($urandom_range(KindSpare, KindSpareHi)), $urandom_range(0, 15),
                      now, delta);
      end
   endtask

   initial begin
      for (int i = 0; i < NTimers; i++) begin
         mdl_expiry[i] = '0;
         mdl_armed[i] = 1'b0;
         mdl_order[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, wrap, equal times, due heads, stop cases, unused kinds
      add_req(KindQuery, 0, 64'd5, 64'd0);
      add_req(KindRun, 0, 64'd5, 64'd0);
      add_req(KindSet, 0, 64'd0, 64'd0);
      add_req(KindSet, 15, {64{1'b1}}, {64{1'b1}});
      add_req(KindSet, 7, 64'd100, 64'd50);
      add_req(KindSet, 8, 64'd100, 64'd50);
      add_req(KindReset, 3, 64'd0, 64'd10);
      add_req(KindQuery, 0, 64'd1, 64'd0);
      add_req(KindRun, 0, 64'd0, 64'd0);
      add_req(KindRun, 0, 64'd200, 64'd0);
      add_req(KindQuery, 0, 64'd120, 64'd0);
      add_req(KindRun, 0, 64'd120, 64'd0);
      add_req(KindStop, 8, 64'd130, 64'd0);
      add_req(KindStop, 8, 64'd140, 64'd0);
      add_req(KindReset, 8, 64'd0, 64'd5);
      add_req(KindStop, 12, 64'd77, 64'd0);
      add_req(KindRun, 0, 64'd300, 64'd0);
      add_req(KindRun, 0, 64'd300, 64'd0);
      add_req(KindRun, 0, {64{1'b1}}, 64'd0);
      add_req(KindQuery, 0, 64'd0, 64'd0);
      add_req(KindSpare, 5, 64'd1, 64'd1);
      add_req(KindSpareMid, 10, 64'd1, 64'd1);
      add_req(KindSpareHi, 15, {64{1'b1}}, {64{1'b1}});
      add_req(KindQuery, 0, {64{1'b1}}, 64'd0);
      drain();

      write_idle_wait(64'd0);
      base_now = 64'd500;
      random_reqs(450);
      hold_req = 1'b1;
      drain();

      write_idle_wait({64{1'b1}});
      random_reqs(250);
      drain();
      random_reqs(250);
      drain();

      write_idle_wait({$urandom, $urandom});
      base_now = {64{1'b1}} - 64'd4000;
      random_reqs(450);
      drain();

      $display("%0d requests sent, %0d responses checked, %0d timers expired by run",
               n_sent, n_checked, n_pops);
      $display("idle wait settings: reset value, zero, all ones, random; time wrap covered");
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
